[design/swfd_pkg.sv]
// Shared constants and widths for the sensor window fault detector.
package swfd_pkg;
	localparam int WINDOW_DEFAULT = 300;
	localparam int SAMPLE_W = 12;
	localparam int READING_W = 24;
	localparam int CFG_W = 24;
	localparam int CFG_IDX_W = 3;
	localparam int S1_W = 24;
	localparam int S2_W = 36;
	localparam int MUL_W = 24;
	localparam int PROD_W = 48;
	localparam int ACC_W = 50;
	localparam int NUM_W = 54;
	localparam int DEN_W = 25;
	localparam int VAR_W = 26;

	localparam logic [CFG_IDX_W-1:0] REG_STUCK_NOISE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RAIL_LOW    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAIL_HIGH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_READING_MIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_READING_MAX = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT  = 3'd5;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;
endpackage

[design/swfd_store.sv]
// Sample ring memory with one write port and one registered read port.
module swfd_store import swfd_pkg::*; #(
	parameter int DEPTH = WINDOW_DEFAULT,
	parameter int AW = 9
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic [SAMPLE_W-1:0] wdata,
	input  logic [AW-1:0]       raddr,
	output logic [SAMPLE_W-1:0] rdata
);
	logic [SAMPLE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[design/swfd_div.sv]
// Restoring divider, one quotient bit per cycle.
module swfd_div import swfd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [VAR_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], fits};
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = num_q[VAR_W-1:0];
endmodule

[design/sensor_window_fault_detector_unit.sv]
// Top level of the sensor window fault detector: sequencer, shared multiplier, flags.
//
// Usage: each request on the input channel (in_valid, in_stall) carries one ADC
// sample, one Q.8 concentration reading and its finite flag. The block stores the
// sample in a ring of WINDOW entries and returns one result request on the output
// channel (out_valid, out_stall) with window min, max, Q.4 variance and four flags.
// Configuration registers are written through cfg_wr_en, cfg_index and cfg_data;
// the user must write them only while the block is idle, which it does not enforce.
// The work is a memory scan, one entry per cycle through the single read port,
// followed by four passes through the shared 24 by 24 multiplier and a 54 step
// restoring divider.
// The input is stalled while a request is being worked on; a new request may be
// accepted while the previous result still waits at the output.
// If the receiver stalls, the result is held in the output registers and a finished
// computation waits until the output is free.
// Reset clears the pointer, fill count, previous reading and the registers to their
// defaults; the sample memory needs no clearing since only written entries are read.
module sensor_window_fault_detector_unit import swfd_pkg::*; #(
	parameter int WINDOW = WINDOW_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [SAMPLE_W-1:0]         sample,
	input  logic signed [READING_W-1:0] reading,
	input  logic                        reading_finite,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        stuck,
	output logic                        saturated,
	output logic                        out_of_range,
	output logic                        rate_spike,
	output logic [SAMPLE_W-1:0]         window_min,
	output logic [SAMPLE_W-1:0]         window_max,
	output logic [VAR_W-1:0]            window_variance,
	input  logic                        cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]            cfg_data
);
	localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW = $clog2(WINDOW + 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SCAN = 4'd1;
	localparam logic [3:0] ST_M1   = 4'd2;
	localparam logic [3:0] ST_M2   = 4'd3;
	localparam logic [3:0] ST_M3   = 4'd4;
	localparam logic [3:0] ST_M4   = 4'd5;
	localparam logic [3:0] ST_M5   = 4'd6;
	localparam logic [3:0] ST_DIV  = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	// Configuration registers.
	logic [SAMPLE_W-1:0]         stuck_noise_q, rail_low_q, rail_high_q;
	logic signed [READING_W-1:0] reading_min_q, reading_max_q;
	logic [READING_W-1:0]        rate_limit_q;

	logic [3:0]    state_q;
	logic [AW-1:0] wp_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] scan_q;
	logic          rv_s1, v_s2;
	logic signed [READING_W-1:0] prev_q;
	logic          prev_valid_q;

	logic [SAMPLE_W-1:0] mn_q, mx_q;
	logic [S1_W-1:0]     s1_q;
	logic [S2_W-1:0]     s2_q;
	logic [ACC_W-1:0]    acc_q;
	logic [PROD_W-1:0]   p_q;
	logic                sat_q, oor_q, spike_q;

	logic [SAMPLE_W-1:0] rdata;
	logic                accept, issue, scan_done, out_free;
	logic [MUL_W-1:0]    mul_a, mul_b, n_ext;
	logic signed [READING_W:0] diff;
	logic [READING_W:0]  adiff;
	logic                div_start, div_done;
	logic [VAR_W-1:0]    quo;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign issue     = (state_q == ST_SCAN) && (scan_q != fill_q);
	assign scan_done = (state_q == ST_SCAN) && !issue && !rv_s1 && !v_s2;
	assign out_free  = !out_valid || !out_stall;
	assign n_ext     = MUL_W'(fill_q);

	swfd_store #(.DEPTH(WINDOW), .AW(AW)) u_store (
		.clk   (clk),
		.we    (accept),
		.waddr (wp_q),
		.wdata (sample),
		.raddr (scan_q[AW-1:0]),
		.rdata (rdata)
	);

	// The one multiplier: squares during the scan, then the variance terms.
	always_comb begin
		mul_a = MUL_W'(rdata);
		mul_b = MUL_W'(rdata);
		case (state_q)
			ST_M1: begin
				mul_a = n_ext;
				mul_b = s2_q[MUL_W-1:0];
			end
			ST_M2: begin
				mul_a = n_ext;
				mul_b = MUL_W'(s2_q[S2_W-1:MUL_W]);
			end
			ST_M3: begin
				mul_a = s1_q;
				mul_b = s1_q;
			end
			ST_M4: begin
				mul_a = n_ext;
				mul_b = n_ext;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
	end

	assign div_start = (state_q == ST_M5);

	swfd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({acc_q, 4'b0000}),
		.den    (p_q[DEN_W-1:0]),
		.done   (div_done),
		.quo    (quo)
	);

	// Rate check against the last finite reading.
	assign diff  = (READING_W+1)'(reading) - (READING_W+1)'(prev_q);
	assign adiff = diff[READING_W] ? (READING_W+1)'(-diff) : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stuck_noise_q <= SAMPLE_W'(1);
			rail_low_q    <= SAMPLE_W'(20);
			rail_high_q   <= SAMPLE_W'(4075);
			reading_min_q <= '0;
			reading_max_q <= READING_W'(256000);
			rate_limit_q  <= READING_W'(128000);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_STUCK_NOISE: stuck_noise_q <= cfg_data[SAMPLE_W-1:0];
				REG_RAIL_LOW:    rail_low_q    <= cfg_data[SAMPLE_W-1:0];
				REG_RAIL_HIGH:   rail_high_q   <= cfg_data[SAMPLE_W-1:0];
				REG_READING_MIN: reading_min_q <= cfg_data;
				REG_READING_MAX: reading_max_q <= cfg_data;
				REG_RATE_LIMIT:  rate_limit_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			wp_q         <= '0;
			fill_q       <= '0;
			scan_q       <= '0;
			rv_s1        <= 1'b0;
			v_s2         <= 1'b0;
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			rv_s1 <= issue;
			v_s2  <= rv_s1;
			// A result leaving in the same cycle as the next one is loaded is
			// handled by the output state alone.
			if (out_valid && !out_stall && (state_q != ST_OUT)) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						wp_q    <= (wp_q == AW'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
						if (fill_q != CW'(WINDOW)) begin
							fill_q <= fill_q + 1'b1;
						end
						if (reading_finite) begin
							prev_q       <= reading;
							prev_valid_q <= 1'b1;
						end
						scan_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						scan_q <= scan_q + 1'b1;
					end
					if (scan_done) begin
						state_q <= ST_M1;
					end
				end
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				ST_M3: state_q <= ST_M4;
				ST_M4: state_q <= ST_M5;
				ST_M5: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers: flags on accept, scan sums, variance terms, outputs.
	always_ff @(posedge clk) begin
		if (accept) begin
			sat_q   <= (sample < rail_low_q) || (sample > rail_high_q);
			oor_q   <= !reading_finite || (reading < reading_min_q)
				|| (reading > reading_max_q);
			spike_q <= reading_finite && prev_valid_q
				&& (adiff > {1'b0, rate_limit_q});
			mn_q    <= '1;
			mx_q    <= '0;
			s1_q    <= '0;
			s2_q    <= '0;
		end
		if (rv_s1) begin
			if (rdata < mn_q) mn_q <= rdata;
			if (rdata > mx_q) mx_q <= rdata;
			s1_q <= s1_q + S1_W'(rdata);
		end
		if (v_s2) begin
			s2_q <= s2_q + S2_W'(p_q);
		end
		case (state_q)
			ST_M2: acc_q <= ACC_W'(p_q);
			ST_M3: acc_q <= acc_q + {p_q[ACC_W-MUL_W-1:0], {MUL_W{1'b0}}};
			ST_M4: acc_q <= acc_q - ACC_W'(p_q);
			default: begin
			end
		endcase
		if (state_q == ST_OUT && out_free) begin
			stuck           <= (fill_q == CW'(WINDOW)) && ((mx_q - mn_q) <= stuck_noise_q);
			saturated       <= sat_q;
			out_of_range    <= oor_q;
			rate_spike      <= spike_q;
			window_min      <= mn_q;
			window_max      <= mx_q;
			window_variance <= quo;
		end
	end
endmodule
